// File: rtl/core/slist_pkg.sv
// shared types, codes and sizes of the sequential list engine
// no dependencies: every other file in rtl/core refers to it by scoped names
`default_nettype none

package slist_pkg;

   // list geometry
   localparam int DEPTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // fixed field widths
   localparam int OP_W        = 3;
   localparam int POS_W       = 6;
   localparam int KEY_W       = 32;
   localparam int PAYLOAD_W   = 64;
   localparam int STATUS_W    = 3;
   localparam int INDEX_OUT_W = 5;
   localparam int COUNT_OUT_W = 6;
   localparam int CMP_W       = POS_W + 1;

   // command codes
   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
   localparam logic [OP_W-1:0] OP_RM_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_RM_BACK   = 3'd4;
   localparam logic [OP_W-1:0] OP_RM_AT     = 3'd5;
   localparam logic [OP_W-1:0] OP_FIND      = 3'd6;
   localparam logic [OP_W-1:0] OP_DUMP      = 3'd7;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   // what a result carries besides its status
   localparam logic [1:0] RK_STATUS = 2'd0;
   localparam logic [1:0] RK_HIT    = 2'd1;
   localparam logic [1:0] RK_ENTRY  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [POS_W-1:0]     position;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [INDEX_OUT_W-1:0] index;
      logic [KEY_W-1:0]       key_out;
      logic [PAYLOAD_W-1:0]   payload_out;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic                   last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic                req_load;
      logic                hit_clear;
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
      logic                wr_en;
      logic [IDX_W-1:0]    wr_addr;
      logic                wr_new;
      logic                cmp_en;
      logic [IDX_W-1:0]    cmp_idx;
      logic                rsp_load;
      logic [1:0]          rsp_kind;
      logic [STATUS_W-1:0] rsp_status;
      logic [IDX_W-1:0]    rsp_index;
      logic                rsp_last;
      logic [CNT_W-1:0]    rsp_count;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;
      logic hit;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: rtl/core/slist_datapath.sv
// entry memory, request holding register, key compare and result register
// depends on slist_pkg; driven by slist_controller
`default_nettype none

module slist_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  slist_pkg::req_type     req_payload,
   input  slist_pkg::dp_cmd_type  cmd,
   output slist_pkg::dp_stat_type stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output slist_pkg::rsp_type     rsp_payload
);

   typedef struct packed {
      logic [slist_pkg::KEY_W-1:0]     key;
      logic [slist_pkg::PAYLOAD_W-1:0] payload;
   } entry_type;

   entry_type                   mem [slist_pkg::DEPTH];
   slist_pkg::req_type          req_ff;
   entry_type                   rd_data_ff;
   entry_type                   wr_data;
   entry_type                   hit_entry_ff;
   logic [slist_pkg::IDX_W-1:0] hit_idx_ff;
   logic                        hit_ff;
   logic                        hit_in;
   logic                        key_match;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   slist_pkg::rsp_type          rsp_ff;
   slist_pkg::rsp_type          rsp_in;

   assign wr_data   = cmd.wr_new ? entry_type'{key: req_ff.key, payload: req_ff.payload}
                                 : rd_data_ff;
   assign key_match = cmd.cmp_en && (rd_data_ff.key == req_ff.key);

   // memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   // scan runs upwards, so the last match wins
   always_comb begin
      hit_in = hit_ff;
      if (cmd.hit_clear) begin
         hit_in = 1'b0;
      end else if (key_match) begin
         hit_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_payload;
      end
      if (key_match) begin
         hit_idx_ff   <= cmd.cmp_idx;
         hit_entry_ff <= rd_data_ff;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.status      = cmd.rsp_status;
      rsp_in.entry_count = slist_pkg::COUNT_OUT_W'(cmd.rsp_count);
      rsp_in.last        = cmd.rsp_last;
      unique case (cmd.rsp_kind)
         slist_pkg::RK_HIT: begin
            rsp_in.index       = slist_pkg::INDEX_OUT_W'(hit_idx_ff);
            rsp_in.key_out     = hit_entry_ff.key;
            rsp_in.payload_out = hit_entry_ff.payload;
         end
         slist_pkg::RK_ENTRY: begin
            rsp_in.index       = slist_pkg::INDEX_OUT_W'(cmd.rsp_index);
            rsp_in.key_out     = rd_data_ff.key;
            rsp_in.payload_out = rd_data_ff.payload;
         end
         default: begin
            rsp_in.index = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.slot_free = !rsp_valid_ff || rsp_ready;
   assign stat.hit       = hit_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_payload    = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/slist_controller.sv
// command decoder and sequencer: entry count, walk pointers, datapath commands
// depends on slist_pkg; drives slist_datapath
`default_nettype none

module slist_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  slist_pkg::req_type     req_payload,
   input  slist_pkg::dp_stat_type stat,
   output slist_pkg::dp_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SHIFT  = 3'd1;
   localparam logic [2:0] S_PUT    = 3'd2;
   localparam logic [2:0] S_RESULT = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_FRES   = 3'd5;
   localparam logic [2:0] S_DRD    = 3'd6;
   localparam logic [2:0] S_DLD    = 3'd7;

   logic [2:0]                     state_ff,  state_in;
   logic [slist_pkg::CNT_W-1:0]    count_ff,  count_in;
   logic [slist_pkg::IDX_W-1:0]    ptr_ff,    ptr_in;
   logic [slist_pkg::IDX_W-1:0]    end_ff,    end_in;
   logic [slist_pkg::IDX_W-1:0]    wptr_ff,   wptr_in;
   logic                           rd_more_ff, rd_more_in;
   logic                           pend_ff,   pend_in;
   logic                           is_ins_ff, is_ins_in;
   logic [slist_pkg::STATUS_W-1:0] status_ff, status_in;

   logic                           accept;
   logic [slist_pkg::CMP_W-1:0]    cnt_w;
   logic [slist_pkg::CMP_W-1:0]    pos_w;
   logic [slist_pkg::CMP_W-1:0]    tgt;
   logic                           full;
   logic                           empty;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign cnt_w     = slist_pkg::CMP_W'(count_ff);
   assign pos_w     = slist_pkg::CMP_W'(req_payload.position);
   assign full      = (count_ff == slist_pkg::CNT_W'(slist_pkg::DEPTH));
   assign empty     = (count_ff == '0);

   // target position of the command
   always_comb begin
      unique case (req_payload.op)
         slist_pkg::OP_INS_FRONT, slist_pkg::OP_RM_FRONT: tgt = '0;
         slist_pkg::OP_INS_BACK:                          tgt = cnt_w;
         slist_pkg::OP_RM_BACK:                           tgt = cnt_w - slist_pkg::CMP_W'(1);
         default:                                         tgt = pos_w;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      end_in     = end_ff;
      wptr_in    = wptr_ff;
      rd_more_in = rd_more_ff;
      pend_in    = pend_ff;
      is_ins_in  = is_ins_ff;
      status_in  = status_ff;

      cmd            = '0;
      cmd.rd_addr    = ptr_ff;
      cmd.wr_addr    = wptr_ff;
      cmd.cmp_idx    = wptr_ff;
      cmd.rsp_kind   = slist_pkg::RK_STATUS;
      cmd.rsp_status = status_ff;
      cmd.rsp_index  = ptr_ff;
      cmd.rsp_last   = 1'b1;
      cmd.rsp_count  = count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.req_load  = 1'b1;
               cmd.hit_clear = 1'b1;
               rd_more_in    = 1'b1;
               pend_in       = 1'b0;
               status_in     = slist_pkg::ST_OK;
               unique case (req_payload.op)
                  slist_pkg::OP_INS_FRONT, slist_pkg::OP_INS_BACK,
                  slist_pkg::OP_INS_AT: begin
                     is_ins_in = 1'b1;
                     end_in    = slist_pkg::IDX_W'(tgt);
                     priority if (full) begin
                        status_in = slist_pkg::ST_FULL;
                        state_in  = S_RESULT;
                     end else if (tgt > cnt_w) begin
                        status_in = slist_pkg::ST_BADPOS;
                        state_in  = S_RESULT;
                     end else if (tgt == cnt_w) begin
                        state_in = S_PUT;
                     end else begin
                        ptr_in   = slist_pkg::IDX_W'(cnt_w - slist_pkg::CMP_W'(1));
                        state_in = S_SHIFT;
                     end
                  end
                  slist_pkg::OP_RM_FRONT, slist_pkg::OP_RM_BACK,
                  slist_pkg::OP_RM_AT: begin
                     is_ins_in = 1'b0;
                     end_in    = slist_pkg::IDX_W'(cnt_w - slist_pkg::CMP_W'(1));
                     priority if (empty) begin
                        status_in = slist_pkg::ST_EMPTY;
                        state_in  = S_RESULT;
                     end else if (tgt >= cnt_w) begin
                        status_in = slist_pkg::ST_BADPOS;
                        state_in  = S_RESULT;
                     end else if (tgt == cnt_w - slist_pkg::CMP_W'(1)) begin
                        count_in = count_ff - slist_pkg::CNT_W'(1);
                        state_in = S_RESULT;
                     end else begin
                        ptr_in   = slist_pkg::IDX_W'(tgt + slist_pkg::CMP_W'(1));
                        state_in = S_SHIFT;
                     end
                  end
                  default: begin
                     // find and dump both walk from entry zero
                     ptr_in = '0;
                     end_in = slist_pkg::IDX_W'(cnt_w - slist_pkg::CMP_W'(1));
                     if (empty) begin
                        status_in = slist_pkg::ST_EMPTY;
                        state_in  = S_RESULT;
                     end else if (req_payload.op == slist_pkg::OP_FIND) begin
                        state_in = S_SCAN;
                     end else begin
                        state_in = S_DRD;
                     end
                  end
               endcase
            end
         end

         S_SHIFT: begin
            if (rd_more_ff) begin
               cmd.rd_en = 1'b1;
               pend_in   = 1'b1;
               wptr_in   = is_ins_ff ? ptr_ff + slist_pkg::IDX_W'(1)
                                     : ptr_ff - slist_pkg::IDX_W'(1);
               if (ptr_ff == end_ff) begin
                  rd_more_in = 1'b0;
               end else begin
                  ptr_in = is_ins_ff ? ptr_ff - slist_pkg::IDX_W'(1)
                                     : ptr_ff + slist_pkg::IDX_W'(1);
               end
            end
            if (pend_ff) begin
               cmd.wr_en = 1'b1;
            end
            if (!rd_more_ff) begin
               pend_in = 1'b0;
               if (is_ins_ff) begin
                  state_in = S_PUT;
               end else begin
                  count_in = count_ff - slist_pkg::CNT_W'(1);
                  state_in = S_RESULT;
               end
            end
         end

         S_PUT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_new  = 1'b1;
            cmd.wr_addr = end_ff;
            count_in    = count_ff + slist_pkg::CNT_W'(1);
            state_in    = S_RESULT;
         end

         S_RESULT: begin
            if (stat.slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_SCAN: begin
            if (rd_more_ff) begin
               cmd.rd_en = 1'b1;
               pend_in   = 1'b1;
               wptr_in   = ptr_ff;
               if (ptr_ff == end_ff) begin
                  rd_more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + slist_pkg::IDX_W'(1);
               end
            end
            if (pend_ff) begin
               cmd.cmp_en = 1'b1;
            end
            if (!rd_more_ff) begin
               pend_in  = 1'b0;
               state_in = S_FRES;
            end
         end

         S_FRES: begin
            if (stat.slot_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_kind   = stat.hit ? slist_pkg::RK_HIT : slist_pkg::RK_STATUS;
               cmd.rsp_status = stat.hit ? slist_pkg::ST_OK : slist_pkg::ST_NOTFOUND;
               state_in       = S_IDLE;
            end
         end

         S_DRD: begin
            // the slot is sure to be free in the next cycle, in S_DLD
            if (stat.slot_free) begin
               cmd.rd_en = 1'b1;
               state_in  = S_DLD;
            end
         end

         S_DLD: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_kind   = slist_pkg::RK_ENTRY;
            cmd.rsp_status = slist_pkg::ST_OK;
            cmd.rsp_last   = (ptr_ff == end_ff);
            if (ptr_ff == end_ff) begin
               state_in = S_IDLE;
            end else begin
               ptr_in   = ptr_ff + slist_pkg::IDX_W'(1);
               state_in = S_DRD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         rd_more_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_more_ff <= rd_more_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      end_ff    <= end_in;
      wptr_ff   <= wptr_in;
      is_ins_ff <= is_ins_in;
      status_ff <= status_in;
   end

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= slist_pkg::CNT_W'(slist_pkg::DEPTH))
      else $error("entry count beyond list depth");

   a_load_slot_free : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.slot_free)
      else $error("result loaded over an untaken result");

   a_rd_wr_apart : assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && cmd.wr_en) |-> (cmd.rd_addr != cmd.wr_addr))
      else $error("shift reads and writes the same entry");

   a_drain_pending : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SHIFT || state_ff == S_SCAN) && !rd_more_ff) |-> pend_ff)
      else $error("walk ended with no read in flight");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT) |=> (count_ff == $past(count_ff) + slist_pkg::CNT_W'(1)))
      else $error("insert did not grow the list by one");

endmodule

`default_nettype wire

// File: rtl/core/sequential_list_engine.sv
// sequential list engine: top level joining the controller and the datapath
// depends on slist_pkg, slist_controller and slist_datapath
//
// An ordered list of up to 32 entries, each a 32-bit key and a 64-bit payload, kept in
// a single-port-read, single-port-write memory. One command is taken at a time: req_ready
// is high only while the sequencer is idle, but a finished result sits in its own output
// register, so the next command can be taken while that result still waits on rsp_ready.
// Insert at position p moves the entries at and above p up one per cycle, drains the last
// move, then writes the new entry; appending at the back writes the new entry at once.
// Remove at p moves the entries above p down one, none when the last entry goes; find
// scans all entries and keeps the highest-index match; dump sends one result per entry,
// each waiting for the result register to be free; rejected commands (full, empty, bad
// position) go straight to their result. The entry memory is not cleared at reset and
// needs no clearing pass: only entries below the count are ever read.
`default_nettype none

module sequential_list_engine (
   input  logic               clock,
   input  logic               reset,
   // command transfer
   input  logic               req_valid,
   output logic               req_ready,
   input  slist_pkg::req_type req_payload,
   // result transfer
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output slist_pkg::rsp_type rsp_payload
);

   // command and status bundles between sequencer and datapath
   slist_pkg::dp_cmd_type  dp_cmd;
   slist_pkg::dp_stat_type dp_stat;

   // sequencer: decodes the command, owns the entry count and walks the list
   slist_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .stat        (dp_stat),
      .cmd         (dp_cmd)
   );

   // datapath: entry memory, key compare and the result register
   slist_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (dp_cmd),
      .stat        (dp_stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// File: test/sequential_list_engine_checker.sv
`timescale 1ns / 1ps
// result checker for the sequential list engine: watches both transfers, keeps its own
// copy of the list, predicts every result and compares it field by field
// depends on slist_pkg only

module sequential_list_engine_checker
   import slist_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fault_count,
   output int      open_results,
   output int      stored_entries
);

   localparam int REPORT_LIMIT = 10;

   logic [KEY_W-1:0]     key_list  [DEPTH];
   logic [PAYLOAD_W-1:0] word_list [DEPTH];
   int                   list_len;
   rsp_type              pending_replies [$];

   function void queue_reply(input logic [STATUS_W-1:0] st, input int idx,
                             input logic [KEY_W-1:0] k, input logic [PAYLOAD_W-1:0] w,
                             input logic is_last);
      rsp_type r;
      r.status      = st;
      r.index       = idx[INDEX_OUT_W-1:0];
      r.key_out     = k;
      r.payload_out = w;
      r.entry_count = list_len[COUNT_OUT_W-1:0];
      r.last        = is_last;
      pending_replies.push_back(r);
   endfunction

   function logic [STATUS_W-1:0] insert_entry(input int pos, input logic [KEY_W-1:0] k,
                                              input logic [PAYLOAD_W-1:0] w);
      int i;
      if (list_len >= DEPTH) return ST_FULL;
      if (pos > list_len) return ST_BADPOS;
      for (i = list_len; i > pos; i--) begin
         key_list[i]  = key_list[i-1];
         word_list[i] = word_list[i-1];
      end
      key_list[pos]  = k;
      word_list[pos] = w;
      list_len++;
      return ST_OK;
   endfunction

   function logic [STATUS_W-1:0] remove_entry(input int pos);
      int i;
      if (list_len == 0) return ST_EMPTY;
      if (pos >= list_len) return ST_BADPOS;
      for (i = pos; i + 1 < list_len; i++) begin
         key_list[i]  = key_list[i+1];
         word_list[i] = word_list[i+1];
      end
      list_len--;
      return ST_OK;
   endfunction

   // updates the list copy and queues the results one command causes
   function void replay_list_command(input req_type cmd);
      logic [STATUS_W-1:0] st;
      int                  hit_at;
      int                  i;
      st     = ST_OK;
      hit_at = -1;
      case (cmd.op)
         OP_INS_FRONT: st = insert_entry(0, cmd.key, cmd.payload);
         OP_INS_BACK:  st = insert_entry(list_len, cmd.key, cmd.payload);
         OP_INS_AT:    st = insert_entry(int'(cmd.position), cmd.key, cmd.payload);
         OP_RM_FRONT:  st = remove_entry(0);
         OP_RM_BACK:   st = (list_len == 0) ? ST_EMPTY : remove_entry(list_len - 1);
         OP_RM_AT:     st = remove_entry(int'(cmd.position));
         OP_FIND: begin
            if (list_len == 0) begin
               st = ST_EMPTY;
            end else begin
               // the highest matching index wins
               for (i = 0; i < list_len; i++)
                  if (key_list[i] == cmd.key) hit_at = i;
               if (hit_at < 0) begin
                  st = ST_NOTFOUND;
               end else begin
                  queue_reply(ST_OK, hit_at, key_list[hit_at], word_list[hit_at], 1'b1);
                  return;
               end
            end
         end
         OP_DUMP: begin
            if (list_len == 0) begin
               st = ST_EMPTY;
            end else begin
               for (i = 0; i < list_len; i++)
                  queue_reply(ST_OK, i, key_list[i], word_list[i], i + 1 == list_len);
               return;
            end
         end
         default: st = ST_OK;
      endcase
      queue_reply(st, 0, '0, '0, 1'b1);
   endfunction

   function void judge_result(input rsp_type got);
      rsp_type want;
      if (pending_replies.size() == 0) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT)
            $display("%0t: unexpected result: status %0d index %0d key %h payload %h count %0d last %0b",
                     $time, got.status, got.index, got.key_out, got.payload_out,
                     got.entry_count, got.last);
         return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.index !== want.index ||
          got.key_out !== want.key_out || got.payload_out !== want.payload_out ||
          got.entry_count !== want.entry_count || got.last !== want.last) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT) begin
            $display("%0t: result mismatch", $time);
            $display("   expected status %0d index %0d key %h payload %h count %0d last %0b",
                     want.status, want.index, want.key_out, want.payload_out,
                     want.entry_count, want.last);
            $display("   actual   status %0d index %0d key %h payload %h count %0d last %0b",
                     got.status, got.index, got.key_out, got.payload_out,
                     got.entry_count, got.last);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         pending_replies.delete();
         fault_count = 0;
      end else begin
         if (req_valid && req_ready) replay_list_command(req_payload);
         if (rsp_valid && rsp_ready) judge_result(rsp_payload);
      end
      open_results   = pending_replies.size();
      stored_entries = list_len;
   end

endmodule

// File: test/sequential_list_engine_test.sv
`timescale 1ns / 1ps
// top of the sequential list engine testbench: clock, reset, command stimulus,
// result-side back-pressure and the verdict
// depends on slist_pkg, sequential_list_engine and sequential_list_engine_checker

module sequential_list_engine_test;
   import slist_pkg::*;

   localparam int RANDOM_ITEMS = 385;
   localparam int POS_MAX      = (1 << POS_W) - 1;
   localparam int LONG_HOLD    = 400;
   localparam int TAIL_CYCLES  = 120;
   // slowest correct run: every command a full dump, every result behind the
   // longest sink stall, plus sender gaps, taken several times over
   localparam int CYCLE_LIMIT  = 3_000_000;

   typedef enum {MOOD_GROW, MOOD_SHRINK, MOOD_MIXED} mood_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   int fault_count;
   int open_results;
   int stored_entries;

   // sender side idling mode, and requests for one long sink hold-off
   bit src_calm      = 1'b0;
   int hold_requests = 0;

   // small key pool so that finds hit and duplicate keys build up
   logic [KEY_W-1:0] key_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                      32'h8000_0000, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                                      32'h0000_0002, 32'h1234_5678};

   sequential_list_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   sequential_list_engine_checker watch (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .fault_count    (fault_count),
      .open_results   (open_results),
      .stored_entries (stored_entries)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle length: mostly none or short, now and then long; none at all when calm
   function automatic int idle_gap(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // one command transfer: optional idle gap, then hold valid until accepted
   // called and left at a falling edge
   task automatic send_cmd(input logic [OP_W-1:0] op, input int pos,
                           input logic [KEY_W-1:0] key, input logic [PAYLOAD_W-1:0] word);
      req_type cmd;
      int      gap;
      cmd.op       = op;
      cmd.position = pos[POS_W-1:0];
      cmd.key      = key;
      cmd.payload  = word;
      gap = idle_gap(src_calm);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload = cmd;
      req_valid   = 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   // result side: random stalls, calm stretches, and the long hold-off on request
   initial begin : result_sink
      int stall_left;
      int calm_left;
      int holds_served;
      int r;
      int g;
      stall_left   = 0;
      calm_left    = 0;
      holds_served = 0;
      rsp_ready    = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            // long hold-off, counted here, so the engine backs up onto its input
            holds_served = hold_requests;
            stall_left   = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_ready = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               calm_left = $urandom_range(20, 150);
               rsp_ready = 1'b1;
            end else begin
               g = idle_gap(1'b0);
               if (g == 0) begin
                  rsp_ready = 1'b1;
               end else begin
                  stall_left = g - 1;
                  rsp_ready  = 1'b0;
               end
            end
         end
      end
   end

   // run limit
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      mood_type         mood;
      int               left_in_episode;
      int               n;
      int               size;
      int               r;
      int               p;
      int               pos;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: commands on an empty list
      send_cmd(OP_DUMP,     0, 32'h0, 64'h0);
      send_cmd(OP_FIND,     0, 32'h0, 64'h0);
      send_cmd(OP_RM_FRONT, 0, 32'h0, 64'h0);
      send_cmd(OP_RM_BACK,  0, 32'h0, 64'h0);
      send_cmd(OP_RM_AT,    0, 32'h0, 64'h0);
      // insert position beyond the count
      send_cmd(OP_INS_AT,   1, 32'h1, 64'h1);
      // position equal to the count appends
      send_cmd(OP_INS_AT,   0, 32'h0000_0000, 64'h0);
      send_cmd(OP_INS_FRONT, 0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      // duplicate key zero, further up the list
      send_cmd(OP_INS_BACK, 0, 32'h0000_0000, 64'h5555_5555_5555_5555);
      send_cmd(OP_INS_AT,   3, 32'hA5A5_A5A5, 64'hAAAA_AAAA_AAAA_AAAA);
      send_cmd(OP_INS_AT,   1, 32'h5A5A_5A5A, 64'h0123_4567_89AB_CDEF);
      // position with the top bits set
      send_cmd(OP_INS_AT,   POS_MAX, 32'h2, 64'h2);
      send_cmd(OP_INS_AT,   DEPTH, 32'h3, 64'h3);
      // find: duplicate keys, a missing key, the first entry
      send_cmd(OP_FIND,     0, 32'h0000_0000, 64'h0);
      send_cmd(OP_FIND,     0, 32'h7777_7777, 64'h0);
      send_cmd(OP_FIND,     POS_MAX, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_cmd(OP_DUMP,     0, 32'h0, 64'h0);
      // remove at the count and far past it
      send_cmd(OP_RM_AT,    5, 32'h0, 64'h0);
      send_cmd(OP_RM_AT,    POS_MAX, 32'h0, 64'h0);
      send_cmd(OP_RM_AT,    2, 32'h0, 64'h0);
      send_cmd(OP_RM_BACK,  0, 32'h0, 64'h0);
      send_cmd(OP_RM_FRONT, 0, 32'h0, 64'h0);
      send_cmd(OP_DUMP,     0, 32'h0, 64'h0);
      send_cmd(OP_RM_AT,    1, 32'h0, 64'h0);
      send_cmd(OP_RM_AT,    0, 32'h0, 64'h0);

      // random: episodes that grow, shrink or churn the list, so that full and
      // empty are both reached often, with random content throughout
      mood            = MOOD_GROW;
      left_in_episode = 45;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (left_in_episode == 0) begin
            mood            = mood_type'($urandom_range(0, 2));
            left_in_episode = $urandom_range(20, 60);
            src_calm        = ($urandom_range(0, 3) == 0);
         end
         left_in_episode--;
         if (n == 40) hold_requests++;

         size = stored_entries;
         r    = $urandom_range(0, 99);
         case (mood)
            MOOD_GROW: begin
               if (r < 75)      op = OP_W'($urandom_range(OP_INS_FRONT, OP_INS_AT));
               else if (r < 85) op = OP_W'($urandom_range(OP_RM_FRONT, OP_RM_AT));
               else if (r < 95) op = OP_FIND;
               else             op = OP_DUMP;
            end
            MOOD_SHRINK: begin
               if (r < 70)      op = OP_W'($urandom_range(OP_RM_FRONT, OP_RM_AT));
               else if (r < 80) op = OP_W'($urandom_range(OP_INS_FRONT, OP_INS_AT));
               else if (r < 92) op = OP_FIND;
               else             op = OP_DUMP;
            end
            default: op = OP_W'($urandom_range(OP_INS_FRONT, OP_DUMP));
         endcase

         // positions mostly in range, some past the end, some anywhere
         p = $urandom_range(0, 99);
         if (p >= 90)
            pos = $urandom_range(0, POS_MAX);
         else if (p >= 80)
            pos = $urandom_range(size + ((op <= OP_INS_AT) ? 1 : 0), POS_MAX);
         else if (op <= OP_INS_AT)
            pos = $urandom_range(0, size);
         else
            pos = (size == 0) ? 0 : $urandom_range(0, size - 1);

         key = ($urandom_range(0, 99) < 70) ? key_pool[$urandom_range(0, 7)] : $urandom;
         send_cmd(op, pos, key, {$urandom, $urandom});
      end
      req_valid = 1'b0;

      // drain: every predicted result back, then an idle tail for strays
      while (open_results != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/slist_pkg.sv
rtl/core/slist_datapath.sv
rtl/core/slist_controller.sv
rtl/core/sequential_list_engine.sv
test/sequential_list_engine_checker.sv
test/sequential_list_engine_test.sv
